### hdl/ciqbn_pkg.sv
// ----------------------------------------------------------------------------
// ciqbn_pkg: shared types and constants for the I/Q biquad notch cascade
// Field widths, coefficient slots and register indexes used by all modules.
// ----------------------------------------------------------------------------
package ciqbn_pkg;

   localparam int NUM_STAGES   = 3;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 24;
   localparam int FRAC_BITS    = 8;
   localparam int ACC_WIDTH    = SAMPLE_WIDTH + FRAC_BITS;
   localparam int PROD_WIDTH   = ACC_WIDTH + COEF_WIDTH;
   // five products summed: three guard bits
   localparam int SUM_WIDTH    = PROD_WIDTH + 3;
   localparam int CSHIFT       = COEF_WIDTH - 2;
   localparam int NUM_SECT     = NUM_STAGES * 2;
   localparam int SECT_W       = $clog2(NUM_SECT);
   localparam int BIT_W        = $clog2(ACC_WIDTH);
   localparam int TAP_W        = 3;

   localparam logic [2:0] CSR_ENABLE = 3'd0;
   localparam logic [2:0] CSR_B0     = 3'd1;
   localparam logic [2:0] CSR_B1     = 3'd2;
   localparam logic [2:0] CSR_B2     = 3'd3;
   localparam logic [2:0] CSR_A1     = 3'd4;
   localparam logic [2:0] CSR_A2     = 3'd5;

   localparam logic [TAP_W-1:0] TAP_X0 = 3'd0;
   localparam logic [TAP_W-1:0] TAP_X1 = 3'd1;
   localparam logic [TAP_W-1:0] TAP_X2 = 3'd2;
   localparam logic [TAP_W-1:0] TAP_Y1 = 3'd3;
   localparam logic [TAP_W-1:0] TAP_Y2 = 3'd4;
   localparam logic [TAP_W-1:0] TAP_LAST = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_re;
      logic signed [SAMPLE_WIDTH-1:0] sample_im;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_re;
      logic signed [SAMPLE_WIDTH-1:0] out_im;
   } rsp_type;

   // control from sequencer to multiply-accumulate unit
   typedef struct packed {
      logic start;    // load operands, clear product
      logic clear;    // clear accumulator at first tap
   } mac_ctl_type;

   // round half up by CSHIFT bits then saturate: helper for section output
   function automatic logic signed [ACC_WIDTH-1:0] sect_round(
      input logic signed [SUM_WIDTH-1:0] acc);
      logic signed [SUM_WIDTH-1:0] r;
      logic signed [SUM_WIDTH-CSHIFT-1:0] q;
      logic signed [SUM_WIDTH-CSHIFT-1:0] hi;
      logic signed [SUM_WIDTH-CSHIFT-1:0] lo;
      r  = acc + (SUM_WIDTH'(1) <<< (CSHIFT - 1));
      q  = r[SUM_WIDTH-1:CSHIFT];
      hi = (SUM_WIDTH-CSHIFT)'((1 << (ACC_WIDTH - 1)) - 1);
      lo = -hi - (SUM_WIDTH-CSHIFT)'(1);
      if (q > hi) return hi[ACC_WIDTH-1:0];
      if (q < lo) return lo[ACC_WIDTH-1:0];
      return q[ACC_WIDTH-1:0];
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] out_round(
      input logic signed [ACC_WIDTH-1:0] v);
      logic signed [ACC_WIDTH:0] r;
      logic signed [ACC_WIDTH-FRAC_BITS:0] q;
      r = {v[ACC_WIDTH-1], v} + (ACC_WIDTH+1)'(1 << (FRAC_BITS - 1));
      q = r[ACC_WIDTH:FRAC_BITS];
      if (q > (ACC_WIDTH-FRAC_BITS+1)'((1 << (SAMPLE_WIDTH - 1)) - 1))
         return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      if (q < -(ACC_WIDTH-FRAC_BITS+1)'(1 << (SAMPLE_WIDTH - 1)))
         return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      return q[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

### hdl/ciqbn_mac.sv
// ----------------------------------------------------------------------------
// ciqbn_mac: bit-serial multiply-accumulate
// Shift-add multiply of a signed sample by a signed coefficient, one
// multiplier bit per cycle, accumulated into a section sum.
// ----------------------------------------------------------------------------
module ciqbn_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  ciqbn_pkg::mac_ctl_type                      ctl,
   input  logic signed [ciqbn_pkg::ACC_WIDTH-1:0]      data,
   input  logic signed [ciqbn_pkg::COEF_WIDTH-1:0]     coef,
   output logic                                        done,
   output logic signed [ciqbn_pkg::SUM_WIDTH-1:0]      acc
);

   localparam int AW = ciqbn_pkg::ACC_WIDTH;
   localparam int PW = ciqbn_pkg::PROD_WIDTH;
   localparam int SW = ciqbn_pkg::SUM_WIDTH;
   localparam int BW = ciqbn_pkg::BIT_W;

   logic                 busy_ff, busy_in;
   logic [BW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        mplr_ff, mplr_in;
   logic signed [PW-1:0] mcand_ff, mcand_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic                 done_ff, done_in;

   // one data bit per cycle; top bit has negative weight
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mplr_in  = data;
         mcand_in = PW'(coef);
         prod_in  = '0;
         if (ctl.clear) acc_in = '0;
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            if (cnt_ff == BW'(AW - 1)) prod_in = prod_ff - mcand_ff;
            else                       prod_in = prod_ff + mcand_ff;
         end
         mplr_in  = mplr_ff >> 1;
         mcand_in = mcand_ff <<< 1;
         cnt_in   = cnt_ff + BW'(1);
         if (cnt_ff == BW'(AW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (done_ff) acc_in = acc_ff + SW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

### hdl/complex_iq_biquad_notch_cascade_unit.sv
// ----------------------------------------------------------------------------
// complex_iq_biquad_notch_cascade_unit: I/Q biquad notch cascade
// Three direct-form-I sections per component with shared coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one complex sample per item (valid/stall); rsp_ returns one
//   result per item through an output register. csr_ writes the enable bit
//   (0) and coefficients b0,b1,b2,a1,a2 (1..5); other indexes are ignored.
//   Users must write csr_ only while the block is idle; it is not enforced.
// Timing:
//   Enabled: each section evaluates five taps on one shared bit-serial
//   multiplier (each tap loads, shifts through 24 data bits, accumulates,
//   hands off) and then rounds; 6 sections. The next item is taken once the
//   result is in the output register; multiplier width sets time per item.
//   Bypass: result registered in the cycle after accept; one item per
//   cycle while the output register is free to take it.
//   A filtered item is taken even while a stalled result waits in the output
//   register, so a stalled output holds at most one result while the filter
//   works on the next item; a bypass item waits for the register to free.
// Reset:
//   Clears the enable bit, coefficients and all past values to zero.
//   Also drops a stalled result by clearing rsp_valid; otherwise a stalled result stays on rsp_ until taken.
// ----------------------------------------------------------------------------
module complex_iq_biquad_notch_cascade_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ciqbn_pkg::req_type      req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ciqbn_pkg::rsp_type      rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_wdata
);

   localparam int AW = ciqbn_pkg::ACC_WIDTH;
   localparam int CW = ciqbn_pkg::COEF_WIDTH;
   localparam int SW = ciqbn_pkg::SUM_WIDTH;
   localparam int NS = ciqbn_pkg::NUM_SECT;
   localparam int SEW = ciqbn_pkg::SECT_W;
   localparam int TW = ciqbn_pkg::TAP_W;
   localparam int FB = ciqbn_pkg::FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_SECT  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic                 en_ff;
   logic signed [CW-1:0] coef_ff [5];
   // section index = stage*2 + component
   logic signed [AW-1:0] x1_ff [NS];
   logic signed [AW-1:0] x2_ff [NS];
   logic signed [AW-1:0] y1_ff [NS];
   logic signed [AW-1:0] y2_ff [NS];
   logic signed [AW-1:0] v_ff [2], v_in [2];
   logic [SEW-1:0]       sect_ff, sect_in;
   logic [TW-1:0]        tap_ff, tap_in;
   logic                 hold_ff, hold_in;
   ciqbn_pkg::rsp_type   res_ff, res_in;
   logic                 rv_ff, rv_in;

   ciqbn_pkg::mac_ctl_type mctl;
   logic signed [AW-1:0] mdata;
   logic signed [CW-1:0] mcoef;
   logic                 mdone;
   logic signed [SW-1:0] macc;
   logic signed [AW-1:0] ynew;
   logic                 comp;
   logic                 accept, hand;

   assign comp      = sect_ff[0];
   assign csr_ready = 1'b1;
   assign hand      = !rv_ff || !rsp_stall;
   // filtered items go in while a result waits; bypass needs the register
   assign req_stall = !(state_ff == ST_IDLE) || (!en_ff && !hand);
   assign accept    = req_valid && !req_stall;
   assign ynew      = ciqbn_pkg::sect_round(macc);

   // operand selection for the current tap
   always_comb begin
      unique case (tap_ff)
         ciqbn_pkg::TAP_X0: mdata = v_ff[comp];
         ciqbn_pkg::TAP_X1: mdata = x1_ff[sect_ff];
         ciqbn_pkg::TAP_X2: mdata = x2_ff[sect_ff];
         ciqbn_pkg::TAP_Y1: mdata = y1_ff[sect_ff];
         default:           mdata = y2_ff[sect_ff];
      endcase
      mcoef = coef_ff[tap_ff];
      mctl.start = (state_ff == ST_START);
      mctl.clear = (tap_ff == ciqbn_pkg::TAP_X0);
   end

   ciqbn_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mctl),
      .data  (mdata),
      .coef  (mcoef),
      .done  (mdone),
      .acc   (macc)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      sect_in  = sect_ff;
      tap_in   = tap_ff;
      hold_in  = hold_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      rv_in    = rv_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (en_ff) begin
                  v_in[0]  = {req_data.sample_re, {FB{1'b0}}};
                  v_in[1]  = {req_data.sample_im, {FB{1'b0}}};
                  sect_in  = '0;
                  tap_in   = ciqbn_pkg::TAP_X0;
                  state_in = ST_START;
               end else begin
                  res_in.out_re = req_data.sample_re;
                  res_in.out_im = req_data.sample_im;
                  rv_in = 1'b1;
               end
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            hold_in = 1'b0;
            if (mdone) hold_in = 1'b1;
            if (hold_ff) begin
               hold_in = 1'b0;
               if (tap_ff == ciqbn_pkg::TAP_LAST) state_in = ST_SECT;
               else begin
                  tap_in   = tap_ff + TW'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_SECT: begin
            v_in[comp] = ynew;
            tap_in     = ciqbn_pkg::TAP_X0;
            if (sect_ff == SEW'(NS - 1)) state_in = ST_DONE;
            else begin
               sect_in  = sect_ff + SEW'(1);
               state_in = ST_START;
            end
         end
         ST_DONE: begin
            if (hand) begin
               res_in.out_re = ciqbn_pkg::out_round(v_ff[0]);
               res_in.out_im = ciqbn_pkg::out_round(v_ff[1]);
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         hold_ff  <= 1'b0;
         sect_ff  <= '0;
         tap_ff   <= '0;
         en_ff    <= 1'b0;
         for (int i = 0; i < 5; i++) coef_ff[i] <= '0;
         for (int i = 0; i < NS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         hold_ff  <= hold_in;
         sect_ff  <= sect_in;
         tap_ff   <= tap_in;
         if (csr_valid) begin
            unique case (csr_index)
               ciqbn_pkg::CSR_ENABLE: en_ff <= csr_wdata[0];
               ciqbn_pkg::CSR_B0: coef_ff[0] <= csr_wdata[CW-1:0];
               ciqbn_pkg::CSR_B1: coef_ff[1] <= csr_wdata[CW-1:0];
               ciqbn_pkg::CSR_B2: coef_ff[2] <= csr_wdata[CW-1:0];
               ciqbn_pkg::CSR_A1: coef_ff[3] <= csr_wdata[CW-1:0];
               ciqbn_pkg::CSR_A2: coef_ff[4] <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end
         // history shift at end of each section
         if (state_ff == ST_SECT) begin
            x2_ff[sect_ff] <= x1_ff[sect_ff];
            x1_ff[sect_ff] <= v_ff[comp];
            y2_ff[sect_ff] <= y1_ff[sect_ff];
            y1_ff[sect_ff] <= ynew;
         end
      end
      v_ff   <= v_in;
      res_ff <= res_in;
   end

   // section order: stage s, component c goes to index s*2+c; process
   // stage-major so each component's value chains through the stages
   assign rsp_valid = rv_ff;
   assign rsp_data  = res_ff;

endmodule
